/* sv/int16_to_decimal_ascii_macros.svh */
// ----------------------------------------------------------------------------
// int16_to_decimal_ascii_macros
// Assertion helpers used by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef INT16_TO_DECIMAL_ASCII_MACROS_SVH
`define INT16_TO_DECIMAL_ASCII_MACROS_SVH

// Checked on every clock edge outside reset.
`define I2DA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define I2DA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/i2da_pkg.sv */
// ----------------------------------------------------------------------------
// i2da_pkg
// Types and constants for the 16-bit binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam int unsigned NUM_BITS   = 16;
  localparam int unsigned NUM_DIGITS = 5;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture magnitude, clear BCD
    logic dabble;      // one shift-add-3 step
    logic start_emit;  // align leading digit, load digit count
    logic emit_sign;   // output '-'
    logic emit_digit;  // output top digit, shift digits up
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic neg;        // value is negative
    logic step_last;  // final conversion step in progress
    logic dig_last;   // one digit left to emit
  } stat_t;

endpackage

`default_nettype wire

/* sv/i2da_dp.sv */
// ----------------------------------------------------------------------------
// i2da_dp
// Datapath: serial double-dabble converter and character output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_dp (
  input  wire              clk,
  input  wire              rst_n,
  input  i2da_pkg::in_t    in_item,
  input  i2da_pkg::cmd_t   cmd,
  output i2da_pkg::stat_t  stat,
  output i2da_pkg::out_t   out_item
);
  import i2da_pkg::*;

  logic [15:0] bin_r,  bin_nxt;
  logic [19:0] bcd_r,  bcd_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [2:0]  cnt_r,  cnt_nxt;
  logic        neg_r,  neg_nxt;
  out_t        out_r,  out_nxt;

  logic [19:0] bcd_adj;
  logic [2:0]  ndig;
  logic        neg_in;

  assign neg_in = in_item.kind & in_item.value[15];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  // number of significant digits, at least one
  always_comb begin
    if (bcd_r[19:16] != 4'd0) begin
      ndig = 3'd5;
    end else if (bcd_r[15:12] != 4'd0) begin
      ndig = 3'd4;
    end else if (bcd_r[11:8] != 4'd0) begin
      ndig = 3'd3;
    end else if (bcd_r[7:4] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    out_nxt  = out_r;
    if (cmd.load) begin
      // two's complement negate; 0x8000 maps onto itself = 32768
      bin_nxt  = neg_in ? 16'(~in_item.value + 16'd1) : in_item.value;
      bcd_nxt  = '0;
      step_nxt = '0;
      neg_nxt  = neg_in;
    end
    if (cmd.dabble) begin
      bcd_nxt  = {bcd_adj[18:0], bin_r[15]};
      bin_nxt  = {bin_r[14:0], 1'b0};
      step_nxt = step_r + 4'd1;
    end
    if (cmd.start_emit) begin
      cnt_nxt = ndig;
      unique case (ndig)
        3'd5:    bcd_nxt = bcd_r;
        3'd4:    bcd_nxt = {bcd_r[15:0], 4'd0};
        3'd3:    bcd_nxt = {bcd_r[11:0], 8'd0};
        3'd2:    bcd_nxt = {bcd_r[7:0], 12'd0};
        default: bcd_nxt = {bcd_r[3:0], 16'd0};
      endcase
    end
    if (cmd.emit_sign) begin
      out_nxt.character = CHAR_MINUS;
      out_nxt.last_char = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_nxt.character = CHAR_ZERO + {4'd0, bcd_r[19:16]};
      out_nxt.last_char = (cnt_r == 3'd1);
      bcd_nxt           = {bcd_r[15:0], 4'd0};
      cnt_nxt           = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
      neg_r  <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    out_r <= out_nxt;
  end

  assign stat.neg       = neg_r;
  assign stat.step_last = (step_r == 4'(NUM_BITS - 1));
  assign stat.dig_last  = (cnt_r == 3'd1);
  assign out_item       = out_r;

endmodule

`default_nettype wire

/* sv/i2da_ctrl.sv */
// ----------------------------------------------------------------------------
// i2da_ctrl
// Controller: sequences load, conversion steps, sign and digit output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "int16_to_decimal_ascii_macros.svh"

module i2da_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  i2da_pkg::stat_t  stat,
  output i2da_pkg::cmd_t   cmd,
  output logic             out_strobe
);
  import i2da_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_PREP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.dabble = 1'b1;
        if (stat.step_last) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.start_emit = 1'b1;
        cmd.emit_sign  = stat.neg;
        out_valid_nxt  = stat.neg;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        out_valid_nxt  = 1'b1;
        if (stat.dig_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;

  `I2DA_ASSERT(a_accept_conv,
    start && !busy |=> state_r == S_CONV,
    "accept did not start conversion")
  `I2DA_ASSERT(a_conv_done,
    state_r == S_CONV && stat.step_last |=> state_r == S_PREP,
    "conversion overran")
  `I2DA_ASSERT(a_last_idle,
    cmd.emit_digit && stat.dig_last |=> state_r == S_IDLE && out_valid_r,
    "final digit not followed by idle")
  `I2DA_ASSERT(a_strobe_src,
    out_valid_r |-> $past(state_r) == S_PREP || $past(state_r) == S_EMIT,
    "strobe outside output phase")
  `I2DA_ASSERT_ALWAYS(a_reset_idle,
    !rst_n |=> !out_valid_r && state_r == S_IDLE,
    "reset did not clear controller")

endmodule

`default_nettype wire

/* sv/int16_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// int16_to_decimal_ascii
// 16-bit unsigned/signed value to decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
// Pulse start with in_item while busy is low. The value is converted by a
// bit-serial double-dabble shifter, then the prep state aligns the leading
// digit, and then one digit is output per cycle. Each character appears on
// out_item for exactly one cycle with out_strobe high; a negative signed value
// first gives '-', and last_char marks the final digit. The receiver cannot
// stall, so it must take every beat. Busy stays high from the accept until the
// final digit is registered, and a new start is taken only while idle.
// The final beat may overlap the next accept.
`default_nettype none

module int16_to_decimal_ascii (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  output logic            busy,
  input  i2da_pkg::in_t   in_item,
  output logic            out_strobe,
  output i2da_pkg::out_t  out_item
);
  import i2da_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  i2da_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .stat       (stat),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  i2da_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
